// File: sv/pidfd_pkg.sv
// Shared types, constants and saturating arithmetic helpers for the filtered-derivative PID.
package pidfd_pkg;

  // Word format of the samples, results and word registers (signed Q16.16).
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GAIN_P        = 3'd0,
    REG_GAIN_I        = 3'd1,
    REG_GAIN_D        = 3'd2,
    REG_INTEG_MIN     = 3'd3,
    REG_INTEG_MAX     = 3'd4,
    REG_SAMPLE_PERIOD = 3'd5,
    REG_FILTER_TAU    = 3'd6
  } reg_idx_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_PREP,
    ST_DIV,
    ST_FIN
  } state_t;

  // Products formed on the shared multiplier, in issue order.
  typedef enum logic [2:0] {
    OP_K   = 3'd0,
    OP_P   = 3'd1,
    OP_INC = 3'd2,
    OP_A   = 3'd3,
    OP_B   = 3'd4
  } mul_op_t;

  localparam int MUL_OPS = 5;

  // Quotient bits produced by the divider, one per cycle.
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

  // Saturating sum of two words.
  function automatic word_t sat_add(input word_t a, input word_t b);
    logic signed [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    end
    return s[WORD_BITS-1:0];
  endfunction

  // Saturating difference of two words.
  function automatic word_t sat_sub(input word_t a, input word_t b);
    logic signed [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    end
    return s[WORD_BITS-1:0];
  endfunction

  // Magnitude of a signed word; the most negative word maps to 2^31.
  function automatic logic [WORD_BITS-1:0] mag_of(input word_t a);
    logic [WORD_BITS-1:0] ua;
    ua = a;
    return a[WORD_BITS-1] ? (~ua + 1'b1) : ua;
  endfunction

  // Signed word from sign and magnitude, saturated; big marks an overflowed magnitude.
  function automatic word_t pack_sat(input logic neg, input logic big,
                                     input logic [2*WORD_BITS-1:0] mag);
    logic [WORD_BITS-1:0] lo;
    lo = mag[WORD_BITS-1:0];
    if (neg) begin
      if (big || mag > {{WORD_BITS{1'b0}}, WORD_MIN}) begin
        return WORD_MIN;
      end
      return ~lo + 1'b1;
    end
    if (big || mag > {{WORD_BITS{1'b0}}, WORD_MAX}) begin
      return WORD_MAX;
    end
    return lo;
  endfunction

endpackage

// File: sv/pid_filtered_derivative.sv
// Top level of the PID controller with trapezoidal integrator and filtered derivative.
// An error word passes the multiply, sum, prepare, divide and final steps, and no new
// word is taken until it is done; five products share one 32x32 multiplier
// and the derivative quotient comes from a restoring divider, one bit per cycle.
// A finished result waits in the output register, so the next word is taken meanwhile.
// Reset (synchronous, rst_n low) loads the register defaults and clears the stored
// error, integrator and derivative terms; no clearing pass is needed.
module pid_filtered_derivative
  import pidfd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // Configuration write port
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [WORD_BITS-1:0]    cfg_wdata,
  // Error sample channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [31:0]      in_error_in,
  // Control output channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [31:0]      out_control_out
);

  // Configuration registers.
  word_t       gain_p_r, gain_i_r, gain_d_r, integ_min_r, integ_max_r;
  logic [30:0] sample_period_r;
  logic [29:0] filter_tau_r;

  // Controller state carried between words.
  word_t prev_err_r, integ_r, deriv_r;

  // Sequencer.
  state_t                  state_r, state_nxt;
  logic [2:0]              mul_cnt_r;
  logic [DIV_CNT_BITS-1:0] div_cnt_r;

  // Per-word working registers.
  word_t e_r, s_r, dif_r;
  word_t k_r, p_r, inc_r, a_r, b_r;
  word_t isum_r, num_r, i_r, pi_r;
  logic [2*WORD_BITS-1:0] prod_r;
  logic                   pk_neg_r;
  mul_op_t                pk_op_r;
  logic [WORD_BITS-1:0]   den_r, rem_r, dvd_r;
  logic                   qneg_r, big_r, dz_r;

  // Output register.
  logic  out_valid_r;
  word_t out_data_r;

  logic in_acc, fin_go, mul_issue;
  mul_op_t cur_op;
  logic                 op_a_neg, op_b_neg;
  logic [WORD_BITS-1:0] op_a_mag, op_b_mag;
  logic [WORD_BITS:0]   coef_c;
  logic [WORD_BITS-1:0] coef_mag, den_c, num_mag;
  logic [WORD_BITS-1:0] pk_shift;
  word_t                pk_res, i_clamp, d_c;
  logic [WORD_BITS:0]   div_try;
  logic                 div_ge;

  assign in_acc    = in_valid && !in_stall;
  assign fin_go    = (state_r == ST_FIN) && (!out_valid_r || !out_stall);
  assign mul_issue = (state_r == ST_MUL) && (mul_cnt_r < 3'(MUL_OPS));
  assign cur_op    = mul_op_t'(mul_cnt_r);

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_control_out = out_data_r;

  // Filter coefficients: 2*tau - Ts (signed, exact) and 2*tau + Ts (unsigned, exact).
  assign coef_c   = {2'b00, filter_tau_r, 1'b0} - {2'b00, sample_period_r};
  assign coef_mag = coef_c[WORD_BITS] ? WORD_BITS'(~coef_c + 1'b1) : coef_c[WORD_BITS-1:0];
  assign den_c    = {1'b0, filter_tau_r, 1'b0} + {1'b0, sample_period_r};

  // Operand selection for the shared multiplier, as sign and magnitude.
  always_comb begin
    op_a_neg = 1'b0;
    op_a_mag = '0;
    op_b_neg = 1'b0;
    op_b_mag = '0;
    case (cur_op)
      OP_K: begin
        op_a_neg = gain_i_r[WORD_BITS-1];
        op_a_mag = mag_of(gain_i_r);
        op_b_mag = {1'b0, sample_period_r};
      end
      OP_P: begin
        op_a_neg = gain_p_r[WORD_BITS-1];
        op_a_mag = mag_of(gain_p_r);
        op_b_neg = e_r[WORD_BITS-1];
        op_b_mag = mag_of(e_r);
      end
      OP_INC: begin
        op_a_neg = k_r[WORD_BITS-1];
        op_a_mag = mag_of(k_r);
        op_b_neg = s_r[WORD_BITS-1];
        op_b_mag = mag_of(s_r);
      end
      OP_A: begin
        op_a_neg = gain_d_r[WORD_BITS-1];
        op_a_mag = mag_of(gain_d_r);
        op_b_neg = dif_r[WORD_BITS-1];
        op_b_mag = mag_of(dif_r);
      end
      OP_B: begin
        op_a_neg = coef_c[WORD_BITS];
        op_a_mag = coef_mag;
        op_b_neg = deriv_r[WORD_BITS-1];
        op_b_mag = mag_of(deriv_r);
      end
      default: begin
        op_a_neg = 1'b0;
      end
    endcase
  end

  // Scaling of the registered product: the half in the integrator adds one bit of shift,
  // the factor two in the derivative removes one.
  always_comb begin
    case (pk_op_r)
      OP_INC:  pk_shift = WORD_BITS'(FRAC_BITS + 1);
      OP_A:    pk_shift = WORD_BITS'(FRAC_BITS - 1);
      default: pk_shift = WORD_BITS'(FRAC_BITS);
    endcase
  end

  assign pk_res = pack_sat(pk_neg_r, 1'b0, prod_r >> pk_shift);

  // Integrator clamp; the upper limit is tested first and takes sums above it.
  always_comb begin
    if (isum_r > integ_max_r) begin
      i_clamp = integ_max_r;
    end else if (isum_r < integ_min_r) begin
      i_clamp = integ_min_r;
    end else begin
      i_clamp = isum_r;
    end
  end

  // Divider step: bring in the next dividend bit and trial-subtract the denominator.
  assign num_mag = mag_of(num_r);
  assign div_try = {rem_r, dvd_r[WORD_BITS-1]};
  assign div_ge  = (div_try >= {1'b0, den_r});

  // New derivative term; a zero denominator gives zero.
  assign d_c = dz_r ? '0 : pack_sat(qneg_r, big_r, {{WORD_BITS{1'b0}}, dvd_r});

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_MUL;
      ST_MUL:  if (mul_cnt_r == 3'(MUL_OPS)) state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_DIV;
      ST_DIV:  if (div_cnt_r == DIV_CNT_BITS'(DIV_STEPS - 1)) state_nxt = ST_FIN;
      ST_FIN:  if (fin_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers, configuration and carried state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      mul_cnt_r       <= '0;
      div_cnt_r       <= '0;
      out_valid_r     <= 1'b0;
      prev_err_r      <= '0;
      integ_r         <= '0;
      deriv_r         <= '0;
      gain_p_r        <= word_t'(32'sd65536);
      gain_i_r        <= '0;
      gain_d_r        <= '0;
      integ_min_r     <= WORD_MIN;
      integ_max_r     <= WORD_MAX;
      sample_period_r <= 31'd65536;
      filter_tau_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      mul_cnt_r <= (state_r == ST_MUL) ? mul_cnt_r + 3'd1 : 3'd0;
      div_cnt_r <= (state_r == ST_DIV) ? div_cnt_r + 1'b1 : '0;

      if (fin_go) begin
        out_valid_r <= 1'b1;
        integ_r     <= i_r;
        deriv_r     <= d_c;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc) begin
        prev_err_r <= in_error_in;
      end

      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_GAIN_P:        gain_p_r        <= cfg_wdata;
          REG_GAIN_I:        gain_i_r        <= cfg_wdata;
          REG_GAIN_D:        gain_d_r        <= cfg_wdata;
          REG_INTEG_MIN:     integ_min_r     <= cfg_wdata;
          REG_INTEG_MAX:     integ_max_r     <= cfg_wdata;
          REG_SAMPLE_PERIOD: sample_period_r <= cfg_wdata[30:0];
          REG_FILTER_TAU:    filter_tau_r    <= cfg_wdata[29:0];
          default:           ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          e_r   <= in_error_in;
          s_r   <= sat_add(in_error_in, prev_err_r);
          dif_r <= sat_sub(in_error_in, prev_err_r);
        end
      end
      ST_MUL: begin
        // Issue one product per cycle and scale the previous one.
        if (mul_issue) begin
          prod_r   <= {{WORD_BITS{1'b0}}, op_a_mag} * {{WORD_BITS{1'b0}}, op_b_mag};
          pk_neg_r <= op_a_neg ^ op_b_neg;
          pk_op_r  <= cur_op;
        end
        if (mul_cnt_r != 3'd0) begin
          case (pk_op_r)
            OP_K:    k_r   <= pk_res;
            OP_P:    p_r   <= pk_res;
            OP_INC:  inc_r <= pk_res;
            OP_A:    a_r   <= pk_res;
            OP_B:    b_r   <= pk_res;
            default: ;
          endcase
        end
      end
      ST_SUM: begin
        isum_r <= sat_add(integ_r, inc_r);
        num_r  <= sat_add(a_r, b_r);
      end
      ST_PREP: begin
        // The quotient overflows 32 bits when the top dividend bits reach the denominator.
        i_r    <= i_clamp;
        den_r  <= den_c;
        rem_r  <= {{(WORD_BITS-FRAC_BITS){1'b0}}, num_mag[WORD_BITS-1:FRAC_BITS]};
        dvd_r  <= {num_mag[FRAC_BITS-1:0], {(WORD_BITS-FRAC_BITS){1'b0}}};
        qneg_r <= num_r[WORD_BITS-1];
        big_r  <= ({{FRAC_BITS{1'b0}}, num_mag[WORD_BITS-1:FRAC_BITS]} >= den_c);
        dz_r   <= (den_c == '0);
      end
      ST_DIV: begin
        rem_r <= div_ge ? WORD_BITS'(div_try - {1'b0, den_r}) : div_try[WORD_BITS-1:0];
        dvd_r <= {dvd_r[WORD_BITS-2:0], div_ge};
        pi_r  <= sat_add(p_r, i_r);
      end
      ST_FIN: begin
        if (fin_go) begin
          out_data_r <= sat_add(pi_r, d_c);
        end
      end
      default: ;
    endcase
  end

  // An accepted word always starts the multiply sequence.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_MUL))
    else $error("accepted word did not start the multiply sequence");

  // A result appears only from the final step.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIN))
    else $error("result word raised outside the final step");

  // The divider moves to the final step after its last step.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && div_cnt_r == DIV_CNT_BITS'(DIV_STEPS - 1)) |=> (state_r == ST_FIN))
    else $error("divider did not finish after its last step");

  // With ordered limits the clamped integrator stays between them.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && integ_min_r <= integ_max_r) |->
      (i_r >= integ_min_r && i_r <= integ_max_r))
    else $error("integrator term outside its limits");

endmodule
